// ===== rtl/rounded_rect_coverage_blend_macros.svh =====
// Assertion helpers shared by rrcb_cov and the top-level RTL file.
`ifndef ROUNDED_RECT_COVERAGE_BLEND_MACROS_SVH
`define ROUNDED_RECT_COVERAGE_BLEND_MACROS_SVH

`ifndef SYNTH
// Plain property, checked at every edge outside reset.
`define RRCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rrcb: property failed");
// Implication, consequent checked in the same cycle.
`define RRCB_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrcb: implication failed");
`else
`define RRCB_ASSERT(lbl, prop)
`define RRCB_IMPLIES(lbl, ante, cons)
`endif

`endif

// ===== rtl/rrcb_pkg.sv =====
package rrcb_pkg;

  // Samples per pixel axis, placed at odd eighths.
  localparam int unsigned SUB_N = 4;
  // Coordinates in eighth pixels.
  localparam int unsigned CW = 18;
  // Corner distance magnitude and its square.
  localparam int unsigned RW = 13;
  localparam int unsigned SQW = 26;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_FILL   = 3'd5
  } rrcb_reg_e;

  typedef struct packed {
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic [15:0]        dest_pixel;
  } rrcb_in_t;

  typedef struct packed {
    logic [15:0] result_pixel;
    logic [7:0]  pixel_coverage;
  } rrcb_out_t;

  typedef struct packed {
    logic signed [11:0] rect_left;
    logic signed [11:0] rect_top;
    logic [10:0]        rect_width;
    logic [10:0]        rect_height;
    logic [9:0]         corner_radius;
    logic [31:0]        fill_color;
  } rrcb_cfg_t;

endpackage

// ===== rtl/rrcb_cov.sv =====
`include "rounded_rect_coverage_blend_macros.svh"

module rrcb_cov import rrcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  rrcb_in_t    in_i,
  input  rrcb_cfg_t   cfg_i,
  output logic        cov_valid_o,
  output logic [7:0]  cov_o,
  output logic [15:0] dest_o
);

  localparam int unsigned NS = SUB_N * SUB_N;
  localparam int unsigned HW = $clog2(NS + 1);
  localparam int unsigned DEPTH = 6;

  function automatic logic [7:0] cov_of(input logic [HW-1:0] h);
    logic [11:0] p;
    p = 12'(h) * 12'd255;
    return p[11:4];
  endfunction

  // Derived rectangle geometry, two register levels.
  logic [9:0]            rc;
  logic signed [CW-1:0]  x0_d, x1_d, y0_d, y1_d;
  logic [RW-1:0]         rr_d;
  logic signed [CW-1:0]  x0_q, x1_q, y0_q, y1_q;
  logic [RW-1:0]         rr_q;
  logic signed [CW-1:0]  xl_d, xr_d, yt_d, yb_d;
  logic signed [CW-1:0]  xl_q, xr_q, yt_q, yb_q;
  logic [SQW-1:0]        r2_d, r2_q;

  always_comb begin
    rc = cfg_i.corner_radius;
    if (rc > cfg_i.rect_width[10:1]) rc = cfg_i.rect_width[10:1];
    if (rc > cfg_i.rect_height[10:1]) rc = cfg_i.rect_height[10:1];
    x0_d = CW'($signed({cfg_i.rect_left, 3'b000}));
    y0_d = CW'($signed({cfg_i.rect_top, 3'b000}));
    x1_d = x0_d + $signed(CW'({cfg_i.rect_width, 3'b000}));
    y1_d = y0_d + $signed(CW'({cfg_i.rect_height, 3'b000}));
    rr_d = {rc, 3'b000};
    xl_d = x0_q + $signed(CW'(rr_q));
    xr_d = x1_q - $signed(CW'(rr_q));
    yt_d = y0_q + $signed(CW'(rr_q));
    yb_d = y1_q - $signed(CW'(rr_q));
    r2_d = SQW'(rr_q) * SQW'(rr_q);
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d;
    x1_q <= x1_d;
    y0_q <= y0_d;
    y1_q <= y1_d;
    rr_q <= rr_d;
    xl_q <= xl_d;
    xr_q <= xr_d;
    yt_q <= yt_d;
    yb_q <= yb_d;
    r2_q <= r2_d;
  end

  // Pixel pipeline.
  logic [DEPTH-1:0]     valid_q;
  logic [15:0]          dest_q [DEPTH];
  logic signed [11:0]   s0_px_q, s0_py_q;
  logic signed [CW-1:0] s1_fx_d [SUB_N];
  logic signed [CW-1:0] s1_fy_d [SUB_N];
  logic signed [CW-1:0] s1_fx_q [SUB_N];
  logic signed [CW-1:0] s1_fy_q [SUB_N];
  logic signed [CW-1:0] dfx [SUB_N];
  logic signed [CW-1:0] dfy [SUB_N];
  logic [SUB_N-1:0]     s2_inx_d, s2_iny_d, s2_inx_q, s2_iny_q;
  logic [RW-1:0]        s2_dx_q [SUB_N];
  logic [RW-1:0]        s2_dy_q [SUB_N];
  logic [SUB_N-1:0]     s3_inx_q, s3_iny_q;
  logic [SQW-1:0]       s3_sqx_q [SUB_N];
  logic [SQW-1:0]       s3_sqy_q [SUB_N];
  logic [NS-1:0]        s4_hit_d, s4_hit_q;
  logic [7:0]           s5_cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q[0] <= in_i.dest_pixel;
    for (int k = 1; k < DEPTH; k++) begin
      dest_q[k] <= dest_q[k-1];
    end
    s0_px_q <= in_i.pixel_x;
    s0_py_q <= in_i.pixel_y;
  end

  // Sample positions in eighths.
  always_comb begin
    for (int i = 0; i < SUB_N; i++) begin
      s1_fx_d[i] = CW'($signed({s0_px_q, 3'b000})) + $signed(CW'(2 * i + 1));
      s1_fy_d[i] = CW'($signed({s0_py_q, 3'b000})) + $signed(CW'(2 * i + 1));
    end
  end

  // Inside tests and distance past the corner centers, one axis at a time.
  always_comb begin
    for (int i = 0; i < SUB_N; i++) begin
      s2_inx_d[i] = (s1_fx_q[i] >= x0_q) && (s1_fx_q[i] < x1_q);
      s2_iny_d[i] = (s1_fy_q[i] >= y0_q) && (s1_fy_q[i] < y1_q);
      if (s1_fx_q[i] < xl_q) begin
        dfx[i] = xl_q - s1_fx_q[i];
      end else if (s1_fx_q[i] > xr_q) begin
        dfx[i] = s1_fx_q[i] - xr_q;
      end else begin
        dfx[i] = '0;
      end
      if (s1_fy_q[i] < yt_q) begin
        dfy[i] = yt_q - s1_fy_q[i];
      end else if (s1_fy_q[i] > yb_q) begin
        dfy[i] = s1_fy_q[i] - yb_q;
      end else begin
        dfy[i] = '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SUB_N; j++) begin
      for (int i = 0; i < SUB_N; i++) begin
        s4_hit_d[j * SUB_N + i] = s3_iny_q[j] && s3_inx_q[i] &&
          ((SQW + 1)'(s3_sqx_q[i]) + (SQW + 1)'(s3_sqy_q[j]) <= (SQW + 1)'(r2_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SUB_N; i++) begin
      s1_fx_q[i]  <= s1_fx_d[i];
      s1_fy_q[i]  <= s1_fy_d[i];
      s2_dx_q[i]  <= dfx[i][RW-1:0];
      s2_dy_q[i]  <= dfy[i][RW-1:0];
      s3_sqx_q[i] <= SQW'(s2_dx_q[i]) * SQW'(s2_dx_q[i]);
      s3_sqy_q[i] <= SQW'(s2_dy_q[i]) * SQW'(s2_dy_q[i]);
    end
    s2_inx_q <= s2_inx_d;
    s2_iny_q <= s2_iny_d;
    s3_inx_q <= s2_inx_q;
    s3_iny_q <= s2_iny_q;
    s4_hit_q <= s4_hit_d;
    s5_cov_q <= cov_of(HW'($countones(s4_hit_q)));
  end

  assign cov_valid_o = valid_q[DEPTH-1];
  assign cov_o       = s5_cov_q;
  assign dest_o      = dest_q[DEPTH-1];

  // Nonzero coverage needs a sample inside on both axes, as held in the s2 inside-test registers for that item.
  `RRCB_IMPLIES(a_cov_needs_inside, cov_valid_o && (cov_o != 8'd0),
                $past((|s2_inx_q) && (|s2_iny_q), 3))

endmodule

// ===== rtl/rrcb_blend.sv =====
module rrcb_blend import rrcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cov_valid_i,
  input  logic [7:0]  cov_i,
  input  logic [15:0] dest_i,
  input  logic [31:0] fill_i,
  output logic        out_valid_o,
  output rrcb_out_t   out_o
);

  localparam int unsigned DEPTH = 4;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic [7:0]       fr, fg, fb, fa;
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       cov_q [DEPTH-1];
  logic [15:0]      dest_q [DEPTH-1];
  logic [15:0]      b1_prod_q;
  logic [7:0]       b2_a_q, b2_dr_q, b2_dg_q, b2_db_q;
  logic [7:0]       inv_a;
  logic [15:0]      b3_sr_q, b3_sg_q, b3_sb_q;
  logic             b3_zero_q, b3_full_q;
  logic [15:0]      res_d;
  rrcb_out_t        out_q;

  assign fr = fill_i[31:24];
  assign fg = fill_i[23:16];
  assign fb = fill_i[15:8];
  assign fa = fill_i[7:0];
  assign inv_a = 8'd255 - b2_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DEPTH-2:0], cov_valid_i};
    end
  end

  always_comb begin
    if (b3_zero_q) begin
      res_d = dest_q[2];
    end else if (b3_full_q) begin
      res_d = to565(fr, fg, fb);
    end else begin
      res_d = to565(div255(b3_sr_q), div255(b3_sg_q), div255(b3_sb_q));
    end
  end

  always_ff @(posedge clk_i) begin
    cov_q[0]  <= cov_i;
    dest_q[0] <= dest_i;
    for (int k = 1; k < DEPTH - 1; k++) begin
      cov_q[k]  <= cov_q[k-1];
      dest_q[k] <= dest_q[k-1];
    end
    b1_prod_q <= 16'(fa) * 16'(cov_i);
    b2_a_q    <= div255(b1_prod_q);
    b2_dr_q   <= {dest_q[0][15:11], dest_q[0][15:13]};
    b2_dg_q   <= {dest_q[0][10:5], dest_q[0][10:9]};
    b2_db_q   <= {dest_q[0][4:0], dest_q[0][4:2]};
    b3_sr_q   <= 16'(fr) * 16'(b2_a_q) + 16'(b2_dr_q) * 16'(inv_a);
    b3_sg_q   <= 16'(fg) * 16'(b2_a_q) + 16'(b2_dg_q) * 16'(inv_a);
    b3_sb_q   <= 16'(fb) * 16'(b2_a_q) + 16'(b2_db_q) * 16'(inv_a);
    b3_zero_q <= (b2_a_q == 8'd0);
    b3_full_q <= (b2_a_q == 8'd255);
    out_q.result_pixel   <= res_d;
    out_q.pixel_coverage <= cov_q[2];
  end

  assign out_valid_o = valid_q[DEPTH-1];
  assign out_o       = out_q;

endmodule

// ===== rtl/rounded_rect_coverage_blend.sv =====
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+------------------------------
// pixel in  | start_i, busy_o, pixel_in_i            | taken when start_i && !busy_o
// result    | result_valid_o, result_o               | one-cycle strobe, no backpressure
// config    | cfg_we_i, cfg_idx_i, cfg_data_i        | written on any edge with cfg_we_i
//
// One item enters per clock; busy_o stays low, so a pixel stream runs at full rate.
// The path runs through six stages of coverage (capture, sample positions,
// inside/distance, squares, corner compare, hit count) and four of blending
// (alpha scale, alpha divide and 888 expand, channel mix, 565 pack).
// Derived geometry (clamped radius, corner centers, radius squared) sits in two
// register levels fed from the config registers; they settle before a new item
// reaches the stage that uses them.
// Reset clears the config registers and all valid bits; payload registers are
// left free. The receiver cannot stall, so nothing ever holds.

`include "rounded_rect_coverage_blend_macros.svh"

module rounded_rect_coverage_blend import rrcb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  rrcb_in_t             pixel_in_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 result_valid_o,
  output rrcb_out_t            result_o
);

  rrcb_cfg_t   cfg_q;
  logic        accept;
  logic        cov_valid;
  logic [7:0]  cov;
  logic [15:0] cov_dest;

  // Every stage advances each cycle, so the block never pushes back.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Config registers: write on enable, drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (rrcb_reg_e'(cfg_idx_i))
        REG_LEFT:   cfg_q.rect_left     <= cfg_data_i[11:0];
        REG_TOP:    cfg_q.rect_top      <= cfg_data_i[11:0];
        REG_WIDTH:  cfg_q.rect_width    <= cfg_data_i[10:0];
        REG_HEIGHT: cfg_q.rect_height   <= cfg_data_i[10:0];
        REG_RADIUS: cfg_q.corner_radius <= cfg_data_i[9:0];
        REG_FILL:   cfg_q.fill_color    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coverage: a zero width or height leaves no sample inside, so the
  // empty rectangle falls out as zero coverage and the destination is kept.
  rrcb_cov u_cov (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_i        (pixel_in_i),
    .cfg_i       (cfg_q),
    .cov_valid_o (cov_valid),
    .cov_o       (cov),
    .dest_o      (cov_dest)
  );

  // Blend the scaled fill over the expanded destination.
  rrcb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cov_valid_i (cov_valid),
    .cov_i       (cov),
    .dest_i      (cov_dest),
    .fill_i      (cfg_q.fill_color),
    .out_valid_o (result_valid_o),
    .out_o       (result_o)
  );

  // Each accepted item gives exactly one strobe.
  `RRCB_ASSERT(a_one_result_per_item, result_valid_o == $past(start_i && rst_ni, 10))
  // Zero coverage must hand back the destination of that same item.
  `RRCB_IMPLIES(a_zero_cov_keeps_dest, result_valid_o && (result_o.pixel_coverage == 8'd0),
                result_o.result_pixel == $past(pixel_in_i.dest_pixel, 10))

endmodule
